// File: rtl/rtsr_pkg.sv
// ----------------------------------------------------------------------------
// rtsr_pkg
// shared types and constants of the tile shade remapper
// ----------------------------------------------------------------------------
`default_nettype none

package rtsr_pkg;

    localparam int BYTE_W       = 8;
    localparam int ADDR_W       = 12;
    localparam int LEVEL_W      = 4;
    localparam int LEVEL_SPAN   = 256;
    localparam int QUEUE_DEPTH  = 4;

    // input item kinds
    localparam logic OP_TABLE_WRITE = 1'b0;
    localparam logic OP_TILE_BYTE   = 1'b1;

    // configuration register indexes
    localparam logic [0:0] REG_RLE_MODE    = 1'b0;
    localparam logic [0:0] REG_SHADE_LEVEL = 1'b1;

    // command passed from the front end to the back end
    typedef struct packed {
        logic                 wr;
        logic [ADDR_W-1:0]    addr;
        logic [BYTE_W-1:0]    data;
        logic                 pix;
        logic                 tend;
        logic                 err;
    } cmd_t;

endpackage

`default_nettype wire

// File: rtl/rtsr_front.sv
// ----------------------------------------------------------------------------
// rtsr_front
// accepts items, runs the run-length row counters and issues back-end commands
// ----------------------------------------------------------------------------
`default_nettype none

module rtsr_front #(
    parameter int TILE_SIDE    = 32,
    parameter int SHADE_LEVELS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [23:0]                   s_tdata,   // table_addr, data_byte, pad
    input  wire logic [1:0]                    s_tuser,   // op, start_tile
    input  wire logic                          s_tlast,   // last_byte
    input  wire logic                          rle_mode,
    input  wire logic [rtsr_pkg::LEVEL_W-1:0]  shade_level,
    input  wire logic                          q_full,
    output logic                               push,
    output rtsr_pkg::cmd_t                     push_cmd
);

    localparam int CW = $clog2(TILE_SIDE + 1);
    localparam int LW = $clog2(SHADE_LEVELS);
    localparam int TABLE_DEPTH = SHADE_LEVELS * rtsr_pkg::LEVEL_SPAN;

    logic [CW-1:0] rows_left_reg, rows_left_next;
    logic [CW-1:0] cols_left_reg, cols_left_next;
    logic [CW-1:0] literal_left_reg, literal_left_next;
    logic          in_literal_reg, in_literal_next;

    logic                          accept;
    logic                          op;
    logic                          start_tile;
    logic [rtsr_pkg::ADDR_W-1:0]   table_addr;
    logic [rtsr_pkg::BYTE_W-1:0]   data_byte;
    logic [LW-1:0]                 level_sat;
    logic                          addr_ok;
    logic                          pix, tend, err;

    assign op         = s_tuser[0];
    assign start_tile = s_tuser[1];
    assign table_addr = s_tdata[11:0];
    assign data_byte  = s_tdata[19:12];

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    assign level_sat = ({1'b0, shade_level} >= (rtsr_pkg::LEVEL_W + 1)'(SHADE_LEVELS))
                     ? LW'(SHADE_LEVELS - 1) : shade_level[LW-1:0];
    assign addr_ok   = {1'b0, table_addr} < (rtsr_pkg::ADDR_W + 1)'(TABLE_DEPTH);

    always_comb begin
        logic [7:0]    raw_cnt;
        logic [CW-1:0] cnt;
        logic          row_done;
        rows_left_next    = rows_left_reg;
        cols_left_next    = cols_left_reg;
        literal_left_next = literal_left_reg;
        in_literal_next   = in_literal_reg;
        pix      = 1'b0;
        tend     = 1'b0;
        err      = 1'b0;
        raw_cnt  = '0;
        cnt      = '0;
        row_done = 1'b0;
        if (op == rtsr_pkg::OP_TILE_BYTE && !rle_mode) begin
            pix  = 1'b1;
            tend = s_tlast;
        end else if (op == rtsr_pkg::OP_TILE_BYTE) begin
            if (start_tile) begin
                rows_left_next    = CW'(TILE_SIDE);
                cols_left_next    = CW'(TILE_SIDE);
                literal_left_next = '0;
                in_literal_next   = 1'b0;
            end
            if (in_literal_next) begin
                pix = 1'b1;
                if (literal_left_next != '0) begin
                    literal_left_next = literal_left_next - CW'(1);
                end
                if (literal_left_next == '0) begin
                    in_literal_next = 1'b0;
                    row_done        = (cols_left_next == '0);
                end
            end else begin
                raw_cnt = data_byte[7] ? 8'(9'd256 - {1'b0, data_byte}) : data_byte;
                if (raw_cnt > 8'(cols_left_next)) begin
                    cnt = cols_left_next;
                    err = 1'b1;
                end else begin
                    cnt = CW'(raw_cnt);
                end
                cols_left_next = cols_left_next - cnt;
                if (data_byte[7]) begin
                    row_done = (cols_left_next == '0);
                end else if (cnt != '0) begin
                    literal_left_next = cnt;
                    in_literal_next   = 1'b1;
                end
            end
            if (row_done) begin
                cols_left_next = CW'(TILE_SIDE);
                if (rows_left_next != '0) begin
                    rows_left_next = rows_left_next - CW'(1);
                end
                if (rows_left_next == '0) begin
                    rows_left_next    = CW'(TILE_SIDE);
                    literal_left_next = '0;
                    in_literal_next   = 1'b0;
                    tend              = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_left_reg    <= CW'(TILE_SIDE);
            cols_left_reg    <= CW'(TILE_SIDE);
            literal_left_reg <= '0;
            in_literal_reg   <= 1'b0;
        end else if (accept) begin
            rows_left_reg    <= rows_left_next;
            cols_left_reg    <= cols_left_next;
            literal_left_reg <= literal_left_next;
            in_literal_reg   <= in_literal_next;
        end
    end

    assign push = accept && (op == rtsr_pkg::OP_TILE_BYTE || addr_ok);

    always_comb begin
        push_cmd.wr   = (op == rtsr_pkg::OP_TABLE_WRITE);
        push_cmd.addr = (op == rtsr_pkg::OP_TABLE_WRITE)
                      ? table_addr : rtsr_pkg::ADDR_W'({level_sat, data_byte});
        push_cmd.data = data_byte;
        push_cmd.pix  = pix;
        push_cmd.tend = tend;
        push_cmd.err  = err;
    end

    a_lit_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        in_literal_reg |-> literal_left_reg != '0)
        else $error("literal run active with zero count");

    a_ctrl_cols: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_literal_reg |-> cols_left_reg != '0)
        else $error("control byte expected with no columns left");

    a_tile_reload: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && rle_mode && op == rtsr_pkg::OP_TILE_BYTE && tend)
        |=> (rows_left_reg == CW'(TILE_SIDE) && cols_left_reg == CW'(TILE_SIDE)
             && !in_literal_reg))
        else $error("counters not reloaded after tile end");

endmodule

`default_nettype wire

// File: rtl/rtsr_queue.sv
// ----------------------------------------------------------------------------
// rtsr_queue
// short command queue between front end and back end
// ----------------------------------------------------------------------------
`default_nettype none

module rtsr_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  rtsr_pkg::cmd_t       push_cmd,
    output logic                 full,
    input  wire logic            pop,
    output logic                 head_valid,
    output rtsr_pkg::cmd_t       head_cmd
);

    localparam int DEPTH = rtsr_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);

    rtsr_pkg::cmd_t slot_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]  count_reg, count_next;

    assign full       = (count_reg == NW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? PW'(wr_ptr_reg + PW'(1)) : wr_ptr_reg;
        rd_ptr_next = pop  ? PW'(rd_ptr_reg + PW'(1)) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + NW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && !head_valid))
        else $error("pop from empty queue");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + NW'(1))
        else $error("queue count out of step");

endmodule

`default_nettype wire

// File: rtl/rtsr_back.sv
// ----------------------------------------------------------------------------
// rtsr_back
// shade table memory, pixel lookup and result register
// ----------------------------------------------------------------------------
`default_nettype none

module rtsr_back #(
    parameter int SHADE_LEVELS = 16
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            head_valid,
    input  rtsr_pkg::cmd_t       head_cmd,
    output logic                 pop,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [7:0]           m_tdata,   // out_byte
    output logic [1:0]           m_tuser,   // is_pixel, run_error
    output logic                 m_tlast    // tile_end
);

    localparam int AW    = $clog2(SHADE_LEVELS) + 8;
    localparam int DEPTH = SHADE_LEVELS * rtsr_pkg::LEVEL_SPAN;

    logic [rtsr_pkg::BYTE_W-1:0] shade_mem [DEPTH];
    logic [rtsr_pkg::BYTE_W-1:0] rdata_reg;
    logic [rtsr_pkg::BYTE_W-1:0] byte_reg;
    logic                        pix_reg, tend_reg, err_reg;
    logic                        m_valid_reg;
    logic                        load;

    assign pop  = head_valid && (head_cmd.wr || !m_valid_reg || m_tready);
    assign load = pop && !head_cmd.wr;

    always_ff @(posedge aclk) begin
        if (pop && head_cmd.wr) begin
            shade_mem[head_cmd.addr[AW-1:0]] <= head_cmd.data;
        end
        if (load && head_cmd.pix) begin
            rdata_reg <= shade_mem[head_cmd.addr[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= head_cmd.data;
            pix_reg  <= head_cmd.pix;
            tend_reg <= head_cmd.tend;
            err_reg  <= head_cmd.err;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = pix_reg ? rdata_reg : byte_reg;
    assign m_tuser  = {err_reg, pix_reg};
    assign m_tlast  = tend_reg;

    a_load_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (!m_valid_reg || m_tready))
        else $error("result overwritten before transfer");

    a_pix_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        load && head_cmd.pix |-> !head_cmd.err)
        else $error("run error flagged on a pixel");

    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> m_valid_reg)
        else $error("loaded result not presented");

endmodule

`default_nettype wire

// File: rtl/rle_tile_shade_remap_top.sv
// ----------------------------------------------------------------------------
// rle_tile_shade_remap_top
// shade remapper for run-length coded tile images
//
// input stream s_*: one item per transfer, either a shade table write
// (op 0, table_addr and data_byte) or one tile byte (op 1). table writes
// produce no result; every tile byte produces one result on m_*.
// in run-length mode control bytes are copied and literal pixels are
// remapped through the shade table row picked by shade_level; in raw mode
// every byte is remapped and last_byte becomes tile_end.
// configuration: cfg_wr_en with cfg_index 0 (rle_mode) or 1 (shade_level),
// written only while the block is idle: a rule for the user, not enforced.
// throughput: one item per cycle sustained while m_tready is high, set by the
// single-port table memory that takes one write or one read per cycle.
// path: a tile byte goes through the queue stage, then the registered table
// read, before it appears on m_*.
// reset: row counters reload, rle_mode = 1, shade_level = 1, queue and
// result register empty; table contents stay undefined until written.
// when m_tready is low the result holds, the four-entry queue fills and
// then s_tready drops; table writes still drain past a stalled result.
// ----------------------------------------------------------------------------
`default_nettype none

module rle_tile_shade_remap_top #(
    parameter int TILE_SIDE    = 32,
    parameter int SHADE_LEVELS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [3:0]  cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // table_addr, data_byte, zero pad
    input  wire logic [1:0]  s_tuser,   // op, start_tile
    input  wire logic        s_tlast,   // last_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // out_byte
    output logic [1:0]       m_tuser,   // is_pixel, run_error
    output logic             m_tlast    // tile_end
);

    logic                          rle_mode_reg;
    logic [rtsr_pkg::LEVEL_W-1:0]  shade_level_reg;
    logic                          q_full;
    logic                          push;
    rtsr_pkg::cmd_t                push_cmd;
    logic                          pop;
    logic                          head_valid;
    rtsr_pkg::cmd_t                head_cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rle_mode_reg    <= 1'b1;
            shade_level_reg <= rtsr_pkg::LEVEL_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                rtsr_pkg::REG_RLE_MODE: begin
                    rle_mode_reg <= cfg_wdata[0];
                end
                rtsr_pkg::REG_SHADE_LEVEL: begin
                    shade_level_reg <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    rtsr_front #(
        .TILE_SIDE    (TILE_SIDE),
        .SHADE_LEVELS (SHADE_LEVELS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .rle_mode    (rle_mode_reg),
        .shade_level (shade_level_reg),
        .q_full      (q_full),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    rtsr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    rtsr_back #(
        .SHADE_LEVELS (SHADE_LEVELS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire
